// ----- hw/rtl/srcg_pkg.sv -----
// Shared types and constants for the stereogram row-copy generator.
// Depends on nothing; the front, back and top files take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package srcg_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_IMAGE_HEIGHT = 4'd1;
  localparam logic [3:0] CFG_SEED_WIDTH   = 4'd2;
  localparam logic [3:0] CFG_SHIFT_LIMIT  = 4'd3;

  // Register reset values
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1024;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd768;
  localparam logic [11:0] RST_SEED_WIDTH   = 12'd80;
  localparam logic [7:0]  RST_SHIFT_LIMIT  = 8'd48;

  // Division by 255: floor(x * 2^22 / 255) underestimates by at most one
  localparam int unsigned RECIP_255   = 16448;
  localparam int unsigned RECIP_SHIFT = 22;

  // Rounding offset: (2p + 255) / 510 equals (p + 127) / 255
  localparam logic [16:0] ROUND_OFS = 17'd127;

  // Per-pixel control word carried from front to back
  typedef struct packed {
    logic copy;       // take the pixel from the row buffer
    logic fwd;        // source is the pixel just before this one
    logic row_end;
    logic frame_end;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/srcg_front.sv -----
// Front end: accepts pixels, keeps the raster position and works out the copy source.
// Depends on srcg_pkg for the control word and the reciprocal constants.
`timescale 1ns / 1ps
`default_nettype none

module srcg_front #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_depth,
  input  wire logic [23:0]      in_tex,
  input  wire logic [11:0]      cfg_image_width,
  input  wire logic [11:0]      cfg_image_height,
  input  wire logic [11:0]      cfg_seed_width,
  input  wire logic [7:0]       cfg_shift_limit,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [CW-1:0]         q_col,
  output logic [CW-1:0]         q_src,
  output srcg_pkg::ctl_t        q_ctl,
  output logic [23:0]           q_tex
);

  logic          adv;
  logic          accept;
  logic [12:0]   width_eff;
  logic [12:0]   height_eff;
  logic [12:0]   col_inc;
  logic [12:0]   row_inc;
  logic          row_end;
  logic          frame_end;
  logic [7:0]    far;

  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;

  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [CW-1:0] s1_col_r, s2_col_r, s3_col_r;
  logic [23:0]   s1_tex_r, s2_tex_r, s3_tex_r;
  srcg_pkg::ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [15:0]   s1_p_r;
  logic [16:0]   s2_x_r;
  logic [7:0]    s2_q0_r;
  logic [7:0]    s3_q_r;

  logic [16:0]   x;
  logic [31:0]   prod;
  logic [15:0]   m255;
  logic [16:0]   rem;
  logic [7:0]    q_fix;
  logic [12:0]   back;
  logic [12:0]   col_ext;

  // Advance the whole front while its last stage can drain
  assign adv      = !s3_v_r || !q_full;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign q_push   = s3_v_r && !q_full;

  // Clamp the frame width to what the row buffer holds, and a zero width or height to one
  always_comb begin
    if (cfg_image_width == 12'd0) begin
      width_eff = 13'd1;
    end else if ({1'b0, cfg_image_width} > 13'(MAX_WIDTH)) begin
      width_eff = 13'(MAX_WIDTH);
    end else begin
      width_eff = {1'b0, cfg_image_width};
    end
    height_eff = (cfg_image_height == 12'd0) ? 13'd1 : {1'b0, cfg_image_height};
  end

  // Step the raster position
  always_comb begin
    col_inc   = 13'(col_r) + 13'd1;
    row_inc   = {1'b0, row_r} + 13'd1;
    row_end   = col_inc >= width_eff;
    frame_end = row_end && (row_inc >= height_eff);
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? 12'd0 : row_inc[11:0];
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  assign far = 8'd255 - in_depth;

  // Divide by 255 through the reciprocal, then correct by one step
  always_comb begin
    x     = {1'b0, s1_p_r} + srcg_pkg::ROUND_OFS;
    prod  = 32'(x) * 32'(srcg_pkg::RECIP_255);
    m255  = {s2_q0_r, 8'd0} - {8'd0, s2_q0_r};
    rem   = s2_x_r - {1'b0, m255};
    q_fix = s2_q0_r + 8'(rem >= 17'd255);
  end

  // Work out the copy source at the queue boundary
  always_comb begin
    back         = {1'b0, cfg_seed_width} + {5'd0, s3_q_r};
    col_ext      = 13'(s3_col_r);
    q_col        = s3_col_r;
    q_src        = CW'(col_ext - back);
    q_tex        = s3_tex_r;
    q_ctl        = s3_ctl_r;
    q_ctl.copy   = (back != 13'd0) && (back <= col_ext);
    q_ctl.fwd    = (back == 13'd1);
  end

  // Hold position counters and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r           <= col_r;
      s1_tex_r           <= in_tex;
      s1_ctl_r.copy      <= 1'b0;
      s1_ctl_r.fwd       <= 1'b0;
      s1_ctl_r.row_end   <= row_end;
      s1_ctl_r.frame_end <= frame_end;
      s1_p_r             <= 16'(far) * 16'(cfg_shift_limit);

      s2_col_r <= s1_col_r;
      s2_tex_r <= s1_tex_r;
      s2_ctl_r <= s1_ctl_r;
      s2_x_r   <= x;
      s2_q0_r  <= prod[srcg_pkg::RECIP_SHIFT +: 8];

      s3_col_r <= s2_col_r;
      s3_tex_r <= s2_tex_r;
      s3_ctl_r <= s2_ctl_r;
      s3_q_r   <= q_fix;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/srcg_queue.sv -----
// Short word queue between the front and the back of the generator.
// Generic register queue; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module srcg_queue #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              not_empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == (PW + 1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/srcg_back.sv -----
// Back end: reads the row buffer, picks texture, buffered or forwarded pixel, drives output.
// Depends on srcg_pkg for the control word; holds the row buffer memory.
`timescale 1ns / 1ps
`default_nettype none

module srcg_back #(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  output logic                  q_pop,
  input  wire logic [CW-1:0]    q_col,
  input  wire logic [CW-1:0]    q_src,
  input  wire srcg_pkg::ctl_t   q_ctl,
  input  wire logic [23:0]      q_tex,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [23:0]           out_pix,
  output logic                  out_row_end,
  output logic                  out_frame_end
);

  logic [23:0]    row_mem [MAX_WIDTH];
  logic [23:0]    mem_q_r;

  logic           b2_v_r;
  logic [CW-1:0]  b2_col_r;
  logic [23:0]    b2_tex_r;
  srcg_pkg::ctl_t b2_ctl_r;

  logic           out_v_r;
  logic [23:0]    out_pix_r;
  logic           out_row_end_r;
  logic           out_frame_end_r;

  logic           out_move;
  logic           b2_move;
  logic           b2_load;
  logic           wr_en;
  logic [23:0]    pix;

  // Stage handshakes
  assign out_move = !out_v_r || !out_stall;
  assign b2_move  = b2_v_r && out_move;
  assign b2_load  = !b2_v_r || out_move;
  assign q_pop    = b2_load && q_not_empty;
  assign wr_en    = b2_move;

  // Pick the pixel: the one just before comes from the output register
  always_comb begin
    if (!b2_ctl_r.copy) begin
      pix = b2_tex_r;
    end else if (b2_ctl_r.fwd) begin
      pix = out_pix_r;
    end else begin
      pix = mem_q_r;
    end
  end

  // Row buffer: write on resolve, read at the source on pop
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[b2_col_r] <= pix;
    end
    if (q_pop) begin
      mem_q_r <= row_mem[q_src];
    end
  end

  // Hold valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b2_load)  b2_v_r  <= q_not_empty;
      if (out_move) out_v_r <= b2_v_r;
    end
  end

  // Advance payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_col_r <= q_col;
      b2_tex_r <= q_tex;
      b2_ctl_r <= q_ctl;
    end
    if (b2_move) begin
      out_pix_r       <= pix;
      out_row_end_r   <= b2_ctl_r.row_end;
      out_frame_end_r <= b2_ctl_r.frame_end;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pix       = out_pix_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

`default_nettype wire

// ----- hw/rtl/stereogram_row_copy_generator.sv -----
// Stereogram row-copy generator, top level: configuration registers, front, queue, back.
// Depends on srcg_pkg, srcg_front, srcg_queue and srcg_back.
//
// Takes one pixel per clock in raster order (depth plus the texture pixel for that
// position) and gives one RGB pixel per clock, with row and frame end marks, while no
// stall holds the flow. Sustained rate is one pixel per cycle, set by the single row
// buffer, which takes one read and one write each cycle. Left of the seed width, and
// where the copy source falls left of column zero or on the pixel itself, the texture
// pixel is passed on; elsewhere the pixel already produced seed width plus the depth
// shift columns to the left is repeated. A four-word queue sits between the position
// and shift pipeline and the row buffer, so either side may stall on its own.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce. An index beyond
// the shift limit register is ignored. The row buffer needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module stereogram_row_copy_generator #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_depth,
  input  wire logic [7:0]  in_tex_red,
  input  wire logic [7:0]  in_tex_green,
  input  wire logic [7:0]  in_tex_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_row_end,
  output logic             out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = 2 * CW + 24 + $bits(srcg_pkg::ctl_t);

  logic [11:0] image_width_r;
  logic [11:0] image_height_r;
  logic [11:0] seed_width_r;
  logic [7:0]  shift_limit_r;

  logic           f_push;
  logic [CW-1:0]  f_col, f_src;
  srcg_pkg::ctl_t f_ctl;
  logic [23:0]    f_tex;
  logic           q_full, q_pop, q_not_empty;
  logic [QW-1:0]  q_wdata, q_rdata;
  logic [CW-1:0]  b_col, b_src;
  srcg_pkg::ctl_t b_ctl;
  logic [23:0]    b_tex;
  logic [23:0]    out_pix;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= srcg_pkg::RST_IMAGE_WIDTH;
      image_height_r <= srcg_pkg::RST_IMAGE_HEIGHT;
      seed_width_r   <= srcg_pkg::RST_SEED_WIDTH;
      shift_limit_r  <= srcg_pkg::RST_SHIFT_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srcg_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        srcg_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        srcg_pkg::CFG_SEED_WIDTH:   seed_width_r   <= cfg_wdata;
        srcg_pkg::CFG_SHIFT_LIMIT:  shift_limit_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  srcg_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_depth          (in_depth),
    .in_tex            ({in_tex_red, in_tex_green, in_tex_blue}),
    .cfg_image_width   (image_width_r),
    .cfg_image_height  (image_height_r),
    .cfg_seed_width    (seed_width_r),
    .cfg_shift_limit   (shift_limit_r),
    .q_full            (q_full),
    .q_push            (f_push),
    .q_col             (f_col),
    .q_src             (f_src),
    .q_ctl             (f_ctl),
    .q_tex             (f_tex)
  );

  // Pack one word for the queue
  assign q_wdata = {f_col, f_src, f_ctl, f_tex};
  assign {b_col, b_src, b_ctl, b_tex} = q_rdata;

  srcg_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  srcg_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_pop         (q_pop),
    .q_col         (b_col),
    .q_src         (b_src),
    .q_ctl         (b_ctl),
    .q_tex         (b_tex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pix       (out_pix),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  assign out_red   = out_pix[23:16];
  assign out_green = out_pix[15:8];
  assign out_blue  = out_pix[7:0];

endmodule

`default_nettype wire
